[hdl/fp32r_pkg.sv]
// package: op codes and constants for the fp32 round-to-integral unit
package fp32r_pkg;
    typedef enum logic [2:0] {
        OP_CEIL  = 3'd0,
        OP_FLOOR = 3'd1,
        OP_TRUNC = 3'd2,
        OP_RNE   = 3'd3,
        OP_FRAC  = 3'd4
    } t_op;

    localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
    localparam logic [30:0] EXP_INF   = 31'h7F80_0000;
    localparam logic [31:0] QUIET_BIT = 32'h0040_0000;
    localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
    } t_item;
endpackage

[hdl/fp32r_if.sv]
// valid/ready stream interface carrying one payload per beat
interface fp32r_if #(
    parameter int W = 32
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/fp32_round_to_integral_unit.sv]
// top level: input register, rounding datapath, output register
// One result per operand; one operand accepted per cycle while the output is not
// back-pressured. An operand is held in the input register, passes the rounding
// datapath and is then held in the result register. Back-pressure on the output
// stalls both stages; the input side stays ready while a stage is free.
module fp32_round_to_integral_unit
    import fp32r_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    fp32r_if.sink   i_in,
    fp32r_if.source o_out
);
    logic        r_v1, r_v2;
    t_item       r_item;
    logic [31:0] r_res, core_res;
    logic        adv2, adv1;

    assign adv2 = !r_v2 || o_out.ready;
    assign adv1 = !r_v1 || adv2;
    assign i_in.ready = adv1;
    assign o_out.valid = r_v2;
    assign o_out.data = r_res;

    fp32r_core u_core (.i_op(r_item.op), .i_value(r_item.value), .o_result(core_res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in.valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_in.valid) r_item <= t_item'(i_in.data);
        if (adv2 && r_v1) r_res <= core_res;
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !o_out.ready |=> r_v2 && $stable(r_res))
        else $error("result lost under stall");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && adv2 |=> r_v2)
        else $error("stage 1 beat dropped");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> i_in.ready)
        else $error("input stalled with free stage");
`endif
endmodule

[hdl/fp32r_core.sv]
// combinational round / frac datapath for one binary32 operand
module fp32r_core
    import fp32r_pkg::*;
(
    input  logic [2:0]  i_op,
    input  logic [31:0] i_value,
    output logic [31:0] o_result
);
    logic [31:0] x_mask, rem, tr, half, lsb, rnd, frc, m, f, fs;
    logic [30:0] mag;
    logic [7:0]  bexp;
    logic [4:0]  k, p, e;
    logic        neg, up;

    always_comb begin
        mag  = i_value[30:0];
        bexp = mag[30:23];
        neg  = i_value[31];
        k    = 5'(8'd150 - bexp);
        x_mask = (32'd1 << k) - 32'd1;
        rem  = i_value & x_mask;
        tr   = i_value & ~x_mask;
        half = 32'd1 << (k - 5'd1);
        lsb  = 32'd1 << k;
        // rounding direction
        unique case (i_op)
            OP_CEIL:  up = !neg;
            OP_FLOOR: up = neg;
            OP_RNE: begin
                if (bexp < 8'd127) up = (bexp == 8'd126) && (mag[22:0] != 23'd0);
                else up = (rem > half) || ((rem == half) && ((tr & lsb) != 32'd0));
            end
            default: up = 1'b0;
        endcase
        if (mag == 31'd0 || bexp >= 8'd150) rnd = i_value;
        else if (bexp < 8'd127) rnd = up ? ({i_value[31], 31'd0} | ONE_BITS)
                                         : {i_value[31], 31'd0};
        else if (rem == 32'd0) rnd = i_value;
        else rnd = up ? tr + lsb : tr;

        // fractional part: normalize the leftover bits
        e = 5'(bexp - 8'd127);
        m = {8'd0, 1'b1, mag[22:0]};
        f = m & ((32'd1 << (5'd23 - e)) - 32'd1);
        p = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (f[i]) p = 5'(i);
        end
        fs = (f << (5'd23 - p)) & 32'h007F_FFFF;
        if (mag == 31'd0 || bexp >= 8'd150) frc = 32'd0;
        else if (bexp < 8'd127) frc = i_value;
        else if (f == 32'd0) frc = 32'd0;
        else frc = {i_value[31], 8'(9'(p) + 9'(e) + 9'd104), fs[22:0]};

        if (mag > EXP_INF) o_result = i_value | QUIET_BIT;
        else if (mag == EXP_INF) o_result = (i_op == OP_FRAC) ? CANON_NAN : i_value;
        else if (i_op <= OP_RNE) o_result = rnd;
        else if (i_op == OP_FRAC) o_result = frc;
        else o_result = i_value;
    end
endmodule
